FILE: src/rqhs_pkg.sv
// Shared types, widths, reset values and the shade table of the quadric hit shader.
package rqhs_pkg;

  localparam int FIELD_W = 16;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int CRD_W = FIELD_W + 1;
  localparam int PROD1_W = 2 * CRD_W;
  localparam int PROD2_W = PROD1_W + CRD_W;
  localparam int SUM_W = 54;
  localparam int A_W = SUM_W - 20;
  localparam int B_W = SUM_W - 14;
  localparam int C_W = SUM_W - 8;
  localparam int FA_W = A_W + 2;
  localparam int BSQ_W = 2 * B_W;
  localparam int PAC_W = FA_W + C_W;
  localparam int DISC_W = PAC_W + 1;
  localparam int SQ_BITS = 41;
  localparam int NUM_W = 42;
  localparam int DEN_W = A_W + 1;
  localparam int DIST_W = 16;
  localparam int FRAC_W = 8;
  localparam int SHADE_W = 4;
  localparam int NUM_REGS = 7;
  localparam int IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_QUAD_X  = 3'd0,
    REG_QUAD_Y  = 3'd1,
    REG_QUAD_Z  = 3'd2,
    REG_LIN_X   = 3'd3,
    REG_LIN_Y   = 3'd4,
    REG_LIN_Z   = 3'd5,
    REG_CONST   = 3'd6
  } cfg_reg_e;

  localparam logic [FIELD_W-1:0] REG_RESET [NUM_REGS] = '{
    16'h0100, 16'hFF00, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'hF700
  };

  localparam logic [DIST_W-1:0] BAND_EDGE [8] = '{
    16'd128, 16'd320, 16'd576, 16'd832, 16'd1088, 16'd1344, 16'd1600, 16'd2560
  };

  localparam logic [SHADE_W-1:0] SHADE_NONE = 4'd0;
  localparam logic [SHADE_W-1:0] SHADE_FAR  = 4'd9;

  function automatic logic [SHADE_W-1:0] shade_of(input logic [DIST_W-1:0] dist_v);
    logic [SHADE_W-1:0] s;
    s = SHADE_FAR;
    for (int i = 7; i >= 0; i--) begin
      if (dist_v < BAND_EDGE[i]) begin
        s = SHADE_W'(i + 1);
      end
    end
    return s;
  endfunction

endpackage

FILE: src/rqhs_ray_if.sv
// Ray channel: origin and direction beat with valid/ready.
interface rqhs_ray_if;
  logic                          valid;
  logic                          ready;
  logic [rqhs_pkg::FIELD_W-1:0] org_x;
  logic [rqhs_pkg::FIELD_W-1:0] org_y;
  logic [rqhs_pkg::FIELD_W-1:0] org_z;
  logic [rqhs_pkg::FIELD_W-1:0] dir_x;
  logic [rqhs_pkg::FIELD_W-1:0] dir_y;
  logic [rqhs_pkg::FIELD_W-1:0] dir_z;

  modport source (output valid, org_x, org_y, org_z, dir_x, dir_y, dir_z, input ready);
  modport sink (input valid, org_x, org_y, org_z, dir_x, dir_y, dir_z, output ready);
endinterface

FILE: src/rqhs_hit_if.sv
// Hit channel: hit flag, distance and shade code beat with valid/ready.
interface rqhs_hit_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [rqhs_pkg::DIST_W-1:0]  hit_dist;
  logic [rqhs_pkg::SHADE_W-1:0] shade_code;

  modport source (output valid, hit, hit_dist, shade_code, input ready);
  modport sink (input valid, hit, hit_dist, shade_code, output ready);
endinterface

FILE: src/rqhs_sqrt_pipe.sv
// Pipelined floor square root, one result bit per stage, with a sideband carried along.
module rqhs_sqrt_pipe #(
  parameter int IN_W = rqhs_pkg::DISC_W,
  parameter int R_BITS = rqhs_pkg::SQ_BITS,
  parameter int SB_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [IN_W-1:0]   rad_i,
  input  logic [SB_W-1:0]   sb_i,
  output logic              valid_o,
  output logic [R_BITS-1:0] root_o,
  output logic [SB_W-1:0]   sb_o
);

  logic [IN_W-1:0]   rem_q  [R_BITS];
  logic [R_BITS-1:0] root_q [R_BITS];
  logic [SB_W-1:0]   sb_q   [R_BITS];
  logic              v_q    [R_BITS];

  for (genvar s = 0; s < R_BITS; s++) begin : g_stage
    localparam int B = R_BITS - 1 - s;
    logic [IN_W-1:0]   rem_in;
    logic [R_BITS-1:0] root_in;
    logic [SB_W-1:0]   sb_in;
    logic              v_in;
    logic [IN_W-1:0]   inc;

    if (s == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign sb_in   = sb_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign sb_in   = sb_q[s-1];
      assign v_in    = v_q[s-1];
    end

    assign inc = (IN_W'(root_in) << (B + 1)) | (IN_W'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_q[s] <= sb_in;
        if (rem_in >= inc) begin
          rem_q[s]  <= rem_in - inc;
          root_q[s] <= root_in | (R_BITS'(1) << B);
        end else begin
          rem_q[s]  <= rem_in;
          root_q[s] <= root_in;
        end
      end
    end
  end

  assign valid_o = v_q[R_BITS-1];
  assign root_o  = root_q[R_BITS-1];
  assign sb_o    = sb_q[R_BITS-1];

endmodule

FILE: src/rqhs_div_pipe.sv
// Pipelined fixed-point restoring divider with a saturating quotient, one bit per stage.
module rqhs_div_pipe #(
  parameter int N_W = rqhs_pkg::NUM_W,
  parameter int D_W = rqhs_pkg::DEN_W,
  parameter int FRAC = rqhs_pkg::FRAC_W,
  parameter int Q_W = rqhs_pkg::DIST_W,
  parameter int SB_W = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [N_W-1:0]  num_i,
  input  logic [D_W-1:0]  den_i,
  input  logic [SB_W-1:0] sb_i,
  output logic            valid_o,
  output logic [Q_W-1:0]  quot_o,
  output logic [SB_W-1:0] sb_o
);

  localparam int RW = N_W + FRAC;
  localparam int CMP_W = (RW > D_W + Q_W) ? RW : D_W + Q_W;

  logic [RW-1:0]   rem0;
  logic            ovf0;
  logic [RW-1:0]   rem_q  [Q_W+1];
  logic [Q_W-1:0]  quot_q [Q_W+1];
  logic [D_W-1:0]  den_q  [Q_W+1];
  logic            ovf_q  [Q_W+1];
  logic [SB_W-1:0] sb_q   [Q_W+1];
  logic            v_q    [Q_W+1];

  assign rem0 = {num_i, {FRAC{1'b0}}};
  assign ovf0 = CMP_W'(rem0) >= (CMP_W'(den_i) << Q_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem0;
      quot_q[0] <= '0;
      den_q[0]  <= den_i;
      ovf_q[0]  <= ovf0;
      sb_q[0]   <= sb_i;
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int J = Q_W - 1 - s;
    logic [CMP_W-1:0] dsh;

    assign dsh = CMP_W'(den_q[s]) << J;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s+1] <= den_q[s];
        ovf_q[s+1] <= ovf_q[s];
        sb_q[s+1]  <= sb_q[s];
        if (CMP_W'(rem_q[s]) >= dsh) begin
          rem_q[s+1]  <= rem_q[s] - dsh[RW-1:0];
          quot_q[s+1] <= quot_q[s] | (Q_W'(1) << J);
        end else begin
          rem_q[s+1]  <= rem_q[s];
          quot_q[s+1] <= quot_q[s];
        end
      end
    end
  end

  assign valid_o = v_q[Q_W];
  assign quot_o  = ovf_q[Q_W] ? '1 : quot_q[Q_W];
  assign sb_o    = sb_q[Q_W];

endmodule

FILE: src/ray_quadric_hit_shade_unit.sv
// Top level of the ray / axis-aligned quadric hit and shade pipeline.
//
// A ray beat (origin Q8.8, direction Q2.14) enters on ray_i; one hit beat per ray
// leaves on hit_o carrying the hit flag, the nearest strictly positive root as an
// unsigned saturating Q8.8 distance, and a shade code from 0 (no hit) to 9.
// The seven quadric coefficients are written through cfg_we_i, cfg_idx_i and
// cfg_data_i while no ray is in flight; indexes beyond six are ignored.
// Five stages form A, B, C and the discriminant, 41 stages compute the square
// root one bit at a time, one stage forms the two root numerators, 17 stages
// divide both roots in parallel one quotient bit at a time, and one output
// register holds the finished beat.
// Throughput is one ray per cycle while the receiver does not stall; the square
// root and division chains set the latency but not the rate.
// Reset clears all valid bits and loads the coefficient reset values.
// When the receiver stalls, the whole pipeline holds, ray_i.ready falls and
// nothing is lost or repeated.
module ray_quadric_hit_shade_unit #(
  parameter int COORD_WIDTH = rqhs_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rqhs_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [rqhs_pkg::FIELD_W-1:0]  cfg_data_i,
  rqhs_ray_if.sink                      ray_i,
  rqhs_hit_if.source                    hit_o
);

  localparam int CRD_W = rqhs_pkg::CRD_W;
  localparam int P1_W = rqhs_pkg::PROD1_W;
  localparam int P2_W = rqhs_pkg::PROD2_W;
  localparam int SUM_W = rqhs_pkg::SUM_W;
  localparam int A_W = rqhs_pkg::A_W;
  localparam int B_W = rqhs_pkg::B_W;
  localparam int C_W = rqhs_pkg::C_W;
  localparam int FA_W = rqhs_pkg::FA_W;
  localparam int BSQ_W = rqhs_pkg::BSQ_W;
  localparam int PAC_W = rqhs_pkg::PAC_W;
  localparam int DISC_W = rqhs_pkg::DISC_W;
  localparam int SQ_BITS = rqhs_pkg::SQ_BITS;
  localparam int NUM_W = rqhs_pkg::NUM_W;
  localparam int DEN_W = rqhs_pkg::DEN_W;
  localparam int DIST_W = rqhs_pkg::DIST_W;
  localparam int FW = rqhs_pkg::FIELD_W;
  localparam int ExtSh = (COORD_WIDTH < FW) ? FW - COORD_WIDTH : 0;
  localparam bit ZeroExt = COORD_WIDTH > FW;
  localparam int BH_W = B_W / 2;
  localparam int CH_W = C_W / 2;
  localparam int SB_W = 1 + A_W + B_W;
  localparam int N_W = NUM_W + 1;

  function automatic logic signed [CRD_W-1:0] ext(input logic [FW-1:0] v);
    logic [FW-1:0] t;
    t = v << ExtSh;
    if (ZeroExt) begin
      return signed'({1'b0, v});
    end
    return signed'({t[FW-1], t}) >>> ExtSh;
  endfunction

  logic en;
  logic out_v_q;

  assign en = !out_v_q || hit_o.ready;
  assign ray_i.ready = en;

  // Configuration registers.
  logic [FW-1:0] cfg_q [rqhs_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rqhs_pkg::NUM_REGS; i++) begin
        cfg_q[i] <= rqhs_pkg::REG_RESET[i];
      end
    end else if (cfg_we_i) begin
      case (rqhs_pkg::cfg_reg_e'(cfg_idx_i))
        rqhs_pkg::REG_QUAD_X: cfg_q[0] <= cfg_data_i;
        rqhs_pkg::REG_QUAD_Y: cfg_q[1] <= cfg_data_i;
        rqhs_pkg::REG_QUAD_Z: cfg_q[2] <= cfg_data_i;
        rqhs_pkg::REG_LIN_X:  cfg_q[3] <= cfg_data_i;
        rqhs_pkg::REG_LIN_Y:  cfg_q[4] <= cfg_data_i;
        rqhs_pkg::REG_LIN_Z:  cfg_q[5] <= cfg_data_i;
        rqhs_pkg::REG_CONST:  cfg_q[6] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [CRD_W-1:0] org_w [3];
  logic signed [CRD_W-1:0] dir_w [3];
  logic signed [CRD_W-1:0] qc [3];
  logic signed [CRD_W-1:0] lc [3];
  logic signed [CRD_W-1:0] kc;

  always_comb begin
    org_w[0] = ext(ray_i.org_x);
    org_w[1] = ext(ray_i.org_y);
    org_w[2] = ext(ray_i.org_z);
    dir_w[0] = ext(ray_i.dir_x);
    dir_w[1] = ext(ray_i.dir_y);
    dir_w[2] = ext(ray_i.dir_z);
    for (int i = 0; i < 3; i++) begin
      qc[i] = ext(cfg_q[i]);
      lc[i] = ext(cfg_q[3+i]);
    end
    kc = ext(cfg_q[6]);
  end

  // Stage 1: coefficient products.
  logic                    v1_q;
  logic signed [CRD_W-1:0] o1_q [3];
  logic signed [CRD_W-1:0] d1_q [3];
  logic signed [P1_W-1:0]  qd1_q [3];
  logic signed [P1_W-1:0]  qo1_q [3];
  logic signed [P1_W-1:0]  ld1_q [3];
  logic signed [P1_W-1:0]  lo1_q [3];

  // Stage 2: cubic terms.
  logic                    v2_q;
  logic signed [P2_W-1:0]  ta2_q [3];
  logic signed [P2_W-1:0]  tb2_q [3];
  logic signed [P2_W-1:0]  tc2_q [3];
  logic signed [P1_W-1:0]  ld2_q [3];
  logic signed [P1_W-1:0]  lo2_q [3];

  // Stage 3: A, B and C at scale 2^16.
  logic                    v3_q;
  logic signed [A_W-1:0]   a3_q;
  logic signed [B_W-1:0]   b3_q;
  logic signed [C_W-1:0]   c3_q;
  logic signed [SUM_W-1:0] sa;
  logic signed [SUM_W-1:0] sb;
  logic signed [SUM_W-1:0] sc;
  logic signed [SUM_W-1:0] sa_sh;
  logic signed [SUM_W-1:0] sb_sh;
  logic signed [SUM_W-1:0] sc_sh;

  always_comb begin
    sa = '0;
    sb = '0;
    sc = SUM_W'(kc) <<< 16;
    for (int i = 0; i < 3; i++) begin
      sa = sa + SUM_W'(ta2_q[i]);
      sb = sb + (SUM_W'(tb2_q[i]) <<< 1) + (SUM_W'(ld2_q[i]) <<< 8);
      sc = sc + SUM_W'(tc2_q[i]) + (SUM_W'(lo2_q[i]) <<< 8);
    end
    sa_sh = sa >>> 20;
    sb_sh = sb >>> 14;
    sc_sh = sc >>> 8;
  end

  // Stage 4: magnitudes and partial products of B^2 and 4AC.
  logic [B_W-1:0]          mb;
  logic [A_W-1:0]          ma;
  logic [FA_W-1:0]         mfa;
  logic [C_W-1:0]          mc;
  logic                    v4_q;
  logic                    azero4_q;
  logic                    sdiff4_q;
  logic signed [A_W-1:0]   a4_q;
  logic signed [B_W-1:0]   b4_q;
  logic [2*BH_W-1:0]       bhh4_q;
  logic [2*BH_W-1:0]       bhl4_q;
  logic [2*BH_W-1:0]       bll4_q;
  logic [FA_W+CH_W-1:0]    pch4_q;
  logic [FA_W+CH_W-1:0]    pcl4_q;

  assign mb  = b3_q[B_W-1] ? B_W'(-b3_q) : B_W'(b3_q);
  assign ma  = a3_q[A_W-1] ? A_W'(-a3_q) : A_W'(a3_q);
  assign mfa = {ma, 2'b00};
  assign mc  = c3_q[C_W-1] ? C_W'(-c3_q) : C_W'(c3_q);

  // Stage 5: discriminant.
  logic [BSQ_W-1:0]        bsq;
  logic [PAC_W-1:0]        pac;
  logic                    v5_q;
  logic                    nohit5_q;
  logic signed [A_W-1:0]   a5_q;
  logic signed [B_W-1:0]   b5_q;
  logic [DISC_W-1:0]       disc5_q;

  assign bsq = (BSQ_W'(bhh4_q) << (2 * BH_W)) + (BSQ_W'(bhl4_q) << (BH_W + 1))
             + BSQ_W'(bll4_q);
  assign pac = (PAC_W'(pch4_q) << CH_W) + PAC_W'(pcl4_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= ray_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        o1_q[i]  <= org_w[i];
        d1_q[i]  <= dir_w[i];
        qd1_q[i] <= qc[i] * dir_w[i];
        qo1_q[i] <= qc[i] * org_w[i];
        ld1_q[i] <= lc[i] * dir_w[i];
        lo1_q[i] <= lc[i] * org_w[i];
        ta2_q[i] <= qd1_q[i] * d1_q[i];
        tb2_q[i] <= qo1_q[i] * d1_q[i];
        tc2_q[i] <= qo1_q[i] * o1_q[i];
        ld2_q[i] <= ld1_q[i];
        lo2_q[i] <= lo1_q[i];
      end
      a3_q <= sa_sh[A_W-1:0];
      b3_q <= sb_sh[B_W-1:0];
      c3_q <= sc_sh[C_W-1:0];
      azero4_q <= (a3_q == '0);
      sdiff4_q <= (c3_q != '0) && (a3_q[A_W-1] != c3_q[C_W-1]);
      a4_q     <= a3_q;
      b4_q     <= b3_q;
      bhh4_q   <= mb[B_W-1:BH_W] * mb[B_W-1:BH_W];
      bhl4_q   <= mb[B_W-1:BH_W] * mb[BH_W-1:0];
      bll4_q   <= mb[BH_W-1:0] * mb[BH_W-1:0];
      pch4_q   <= mfa * mc[C_W-1:CH_W];
      pcl4_q   <= mfa * mc[CH_W-1:0];
      a5_q     <= a4_q;
      b5_q     <= b4_q;
      nohit5_q <= azero4_q || (!sdiff4_q && (PAC_W'(bsq) < pac));
      disc5_q  <= sdiff4_q ? DISC_W'(bsq) + DISC_W'(pac) : DISC_W'(bsq) - DISC_W'(pac);
    end
  end

  // Square root.
  logic               sq_v;
  logic [SQ_BITS-1:0] sq_root;
  logic [SB_W-1:0]    sq_sb;

  rqhs_sqrt_pipe #(
    .IN_W   (DISC_W),
    .R_BITS (SQ_BITS),
    .SB_W   (SB_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .rad_i   (disc5_q),
    .sb_i    ({nohit5_q, a5_q, b5_q}),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );

  // Root numerators and denominator.
  logic                  sq_nohit;
  logic signed [A_W-1:0] sq_a;
  logic signed [B_W-1:0] sq_b;
  logic signed [N_W-1:0] n1;
  logic signed [N_W-1:0] n2;
  logic                  vr_q;
  logic                  nhr_q;
  logic                  p1r_q;
  logic                  p2r_q;
  logic [NUM_W-1:0]      mn1r_q;
  logic [NUM_W-1:0]      mn2r_q;
  logic [DEN_W-1:0]      denr_q;

  assign sq_nohit = sq_sb[SB_W-1];
  assign sq_a     = sq_sb[SB_W-2:B_W];
  assign sq_b     = sq_sb[B_W-1:0];
  assign n1 = -N_W'(sq_b) - signed'(N_W'(sq_root));
  assign n2 = -N_W'(sq_b) + signed'(N_W'(sq_root));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (en) begin
      vr_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nhr_q  <= sq_nohit;
      p1r_q  <= (n1 != '0) && (n1[N_W-1] == sq_a[A_W-1]);
      p2r_q  <= (n2 != '0) && (n2[N_W-1] == sq_a[A_W-1]);
      mn1r_q <= n1[N_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
      mn2r_q <= n2[N_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
      denr_q <= sq_a[A_W-1] ? {A_W'(-sq_a), 1'b0} : {A_W'(sq_a), 1'b0};
    end
  end

  // Dividers for both roots.
  logic              dv1;
  logic              dv2;
  logic [DIST_W-1:0] q1;
  logic [DIST_W-1:0] q2;
  logic [1:0]        d1_sb;
  logic              d2_sb;

  rqhs_div_pipe #(
    .N_W  (NUM_W),
    .D_W  (DEN_W),
    .FRAC (rqhs_pkg::FRAC_W),
    .Q_W  (DIST_W),
    .SB_W (2)
  ) u_div_near (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vr_q),
    .num_i   (mn1r_q),
    .den_i   (denr_q),
    .sb_i    ({nhr_q, p1r_q}),
    .valid_o (dv1),
    .quot_o  (q1),
    .sb_o    (d1_sb)
  );

  rqhs_div_pipe #(
    .N_W  (NUM_W),
    .D_W  (DEN_W),
    .FRAC (rqhs_pkg::FRAC_W),
    .Q_W  (DIST_W),
    .SB_W (1)
  ) u_div_far (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vr_q),
    .num_i   (mn2r_q),
    .den_i   (denr_q),
    .sb_i    (p2r_q),
    .valid_o (dv2),
    .quot_o  (q2),
    .sb_o    (d2_sb)
  );

  // Root selection, shading and output register.
  logic                          hit_w;
  logic [DIST_W-1:0]             dist_w;
  logic                          hit_q;
  logic [DIST_W-1:0]             dist_q;
  logic [rqhs_pkg::SHADE_W-1:0]  shade_q;

  always_comb begin
    hit_w = !d1_sb[1] && (d1_sb[0] || d2_sb);
    if (d1_sb[0] && d2_sb) begin
      dist_w = (q1 < q2) ? q1 : q2;
    end else if (d1_sb[0]) begin
      dist_w = q1;
    end else begin
      dist_w = q2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv1 && dv2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q   <= hit_w;
      dist_q  <= hit_w ? dist_w : '0;
      shade_q <= hit_w ? rqhs_pkg::shade_of(dist_w) : rqhs_pkg::SHADE_NONE;
    end
  end

  assign hit_o.valid      = out_v_q;
  assign hit_o.hit        = hit_q;
  assign hit_o.hit_dist   = dist_q;
  assign hit_o.shade_code = shade_q;

endmodule

FILE: dv/ray_quadric_hit_shade_unit_tb.sv
// Self-checking testbench for the ray / quadric hit and shade unit with a bit-exact predictor.
module ray_quadric_hit_shade_unit_tb;

  typedef struct packed {
    logic [15:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] hdist;
    logic [3:0]  shade;
  } hit_t;

  typedef struct {
    ray_t ray;
    logic chk;
    hit_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [rqhs_pkg::IDX_W-1:0] cfg_idx_i;
  logic [rqhs_pkg::FIELD_W-1:0] cfg_data_i;

  rqhs_ray_if ray_if ();
  rqhs_hit_if hit_if ();

  ray_quadric_hit_shade_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .ray_i(ray_if.sink),
    .hit_o(hit_if.source)
  );

  logic [15:0] coef [rqhs_pkg::NUM_REGS];
  hit_t expected_hits [$];
  int errors;
  int recv_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic signed [63:0] fshr(input logic signed [63:0] v, input int k);
    return v >>> k;
  endfunction

  function automatic logic [127:0] isqrt(input logic [127:0] v);
    logic [127:0] r;
    logic [127:0] c;
    r = 0;
    for (int b = 40; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (!(v < c * c)) begin
        r = c;
      end
    end
    return r;
  endfunction

  function automatic hit_t predict_hit(input ray_t r);
    logic signed [63:0] o [3];
    logic signed [63:0] d [3];
    logic signed [63:0] q [3];
    logic signed [63:0] l [3];
    logic signed [63:0] sa, sb, sc, a16, b16, c16, n1, n2, den;
    logic signed [127:0] disc;
    logic [127:0] s;
    logic [63:0] r1, r2, rdist;
    logic p1, p2;
    hit_t h;
    h = '0;
    o[0] = $signed(r.ox); o[1] = $signed(r.oy); o[2] = $signed(r.oz);
    d[0] = $signed(r.dx); d[1] = $signed(r.dy); d[2] = $signed(r.dz);
    for (int i = 0; i < 3; i++) begin
      q[i] = $signed(coef[i]);
      l[i] = $signed(coef[3 + i]);
    end
    sa = 0; sb = 0; sc = 0;
    for (int i = 0; i < 3; i++) begin
      sa += q[i] * d[i] * d[i];
      sb += 2 * q[i] * o[i] * d[i] + l[i] * d[i] * 256;
      sc += q[i] * o[i] * o[i] + l[i] * o[i] * 256;
    end
    sc += $signed(coef[rqhs_pkg::REG_CONST]) * 64'sd65536;
    a16 = fshr(sa, 20);
    b16 = fshr(sb, 14);
    c16 = fshr(sc, 8);
    if (a16 == 0) return h;
    disc = 128'(b16) * 128'(b16) - 128'(4 * a16) * 128'(c16);
    if (disc < 0) return h;
    s = isqrt(disc);
    n1 = -b16 - $signed(s[63:0]);
    n2 = -b16 + $signed(s[63:0]);
    den = 2 * a16;
    p1 = n1 != 0 && ((n1 < 0) == (den < 0));
    p2 = n2 != 0 && ((n2 < 0) == (den < 0));
    r1 = p1 ? ((n1 < 0 ? -n1 : n1) << 8) / (den < 0 ? -den : den) : 0;
    r2 = p2 ? ((n2 < 0 ? -n2 : n2) << 8) / (den < 0 ? -den : den) : 0;
    if (!p1 && !p2) return h;
    if (p1 && p2) rdist = r1 < r2 ? r1 : r2;
    else rdist = p1 ? r1 : r2;
    h.hit = 1'b1;
    h.hdist = rdist > 65535 ? 16'hFFFF : rdist[15:0];
    h.shade = rqhs_pkg::SHADE_FAR;
    for (int i = 7; i >= 0; i--) begin
      if (rdist < rqhs_pkg::BAND_EDGE[i]) h.shade = 4'(i + 1);
    end
    return h;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("beat %0d: %s got %0d expected %0d", recv_count, what, got, want);
    errors++;
  endtask

  // Receiver: stalls on a rotating pattern and compares each beat with the oldest expectation.
  initial begin
    int phase;
    hit_t want;
    phase = 0;
    hit_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hit_if.valid && hit_if.ready) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = expected_hits.pop_front();
          if (hit_if.hit !== want.hit) report_mismatch("hit", hit_if.hit, want.hit);
          if (hit_if.hit_dist !== want.hdist)
            report_mismatch("dist", hit_if.hit_dist, want.hdist);
          if (hit_if.shade_code !== want.shade)
            report_mismatch("shade", hit_if.shade_code, want.shade);
        end
        recv_count++;
      end
      @(negedge clk_i);
      phase++;
      if ((phase / 300) % 3 == 0) hit_if.ready <= 1'b1;
      else if ((phase / 300) % 3 == 1) hit_if.ready <= ($urandom_range(0, 3) != 0);
      else hit_if.ready <= (phase % 7) < 3;
    end
  end

  task automatic write_coef(input rqhs_pkg::cfg_reg_e idx, input logic [15:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    coef[idx] = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain;
    while (expected_hits.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  int gap_left;
  int burst_left;

  task automatic send_ray(input ray_t r, input logic chk, input hit_t want);
    hit_t p;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    end
    if (gap_left != 0) begin
      ray_if.valid <= 1'b0;
      repeat (gap_left) @(negedge clk_i);
    end
    gap_left = 0;
    burst_left--;
    ray_if.valid <= 1'b1;
    {ray_if.org_x, ray_if.org_y, ray_if.org_z, ray_if.dir_x, ray_if.dir_y, ray_if.dir_z} <= r;
    p = predict_hit(r);
    if (chk && p !== want) begin
      $display("directed row prediction differs from table");
      errors++;
    end
    expected_hits.push_back(p);
    do @(posedge clk_i); while (!ray_if.ready);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rnd_dir();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 32768)) - 16384);
      default: return 16'($signed($urandom_range(0, 16384)) - 8192);
    endcase
  endfunction

  function automatic logic [15:0] rnd_org();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 8192)) - 4096);
  endfunction

  function automatic logic [15:0] rnd_coef();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return 16'h0000;
      default: return 16'($signed($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  dir_row_t dir_rows [] = '{
    '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{1'b0, 16'd0, 4'd0}},
    '{'{16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000}, 1'b1, '{1'b1, 16'd768, 4'd4}},
    '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000}, 1'b1, '{1'b0, 16'd0, 4'd0}},
    '{'{16'h0000, 16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000}, 1'b1, '{1'b1, 16'd768, 4'd4}},
    '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000}, 1'b1, '{1'b1, 16'd768, 4'd4}},
    '{'{16'hF800, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000}, 1'b1, '{1'b1, 16'd1280, 4'd6}},
    '{'{16'h0300, 16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{16'h0300, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{16'h0800, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{16'h02FF, 16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, '0},
    '{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
    '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    '{'{16'h8000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{16'h0000, 16'h7FFF, 16'h0000, 16'h2D41, 16'h2D41, 16'h0000}, 1'b0, '0},
    '{'{16'hF700, 16'h0100, 16'h0000, 16'h4000, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '0}
  };

  initial begin
    ray_t r;
    errors = 0;
    recv_count = 0;
    burst_left = 0;
    gap_left = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = rqhs_pkg::REG_QUAD_X;
    cfg_data_i = '0;
    ray_if.valid = 1'b0;
    {ray_if.org_x, ray_if.org_y, ray_if.org_z, ray_if.dir_x, ray_if.dir_y, ray_if.dir_z} = '0;
    for (int i = 0; i < rqhs_pkg::NUM_REGS; i++) coef[i] = rqhs_pkg::REG_RESET[i];
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_ray(dir_rows[i].ray, dir_rows[i].chk, dir_rows[i].want);
    ray_if.valid <= 1'b0;
    drain();

    // Out-of-range index must be ignored; then zero quadratic terms, where A is zero and no hit is expected.
    cfg_we_i = 1'b1;
    cfg_idx_i = 3'd7;
    cfg_data_i = 16'h1234;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    write_coef(rqhs_pkg::REG_QUAD_X, 16'h0000);
    write_coef(rqhs_pkg::REG_QUAD_Y, 16'h0000);
    write_coef(rqhs_pkg::REG_QUAD_Z, 16'h0000);
    send_ray('{16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000}, 1'b1,
             '{1'b0, 16'd0, 4'd0});
    ray_if.valid <= 1'b0;
    drain();
    write_coef(rqhs_pkg::REG_QUAD_X, 16'h7FFF);
    write_coef(rqhs_pkg::REG_CONST, 16'h8000);
    send_ray('{16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h4000, 16'h4000}, 1'b0, '0);
    send_ray('{16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000}, 1'b0, '0);
    ray_if.valid <= 1'b0;
    drain();
    write_coef(rqhs_pkg::REG_CONST, 16'h7FFF);
    send_ray('{16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000}, 1'b0, '0);
    ray_if.valid <= 1'b0;
    drain();
    write_coef(rqhs_pkg::REG_LIN_X, 16'h8000);
    write_coef(rqhs_pkg::REG_LIN_Y, 16'h7FFF);
    write_coef(rqhs_pkg::REG_LIN_Z, 16'hFFFF);
    send_ray('{16'h0100, 16'h0100, 16'h0100, 16'h4000, 16'hC000, 16'h0001}, 1'b0, '0);
    ray_if.valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) begin
        for (int i = 0; i < rqhs_pkg::NUM_REGS; i++)
          write_coef(rqhs_pkg::cfg_reg_e'(i), rqhs_pkg::REG_RESET[i]);
      end else if (ph == 1) begin
        for (int i = 0; i < rqhs_pkg::NUM_REGS; i++)
          write_coef(rqhs_pkg::cfg_reg_e'(i), 16'h8000);
      end else if (ph == 2) begin
        for (int i = 0; i < rqhs_pkg::NUM_REGS; i++)
          write_coef(rqhs_pkg::cfg_reg_e'(i), 16'h7FFF);
      end else begin
        for (int i = 0; i < rqhs_pkg::NUM_REGS; i++)
          write_coef(rqhs_pkg::cfg_reg_e'(i), rnd_coef());
      end
      for (int n = 0; n < 85; n++) begin
        r.ox = rnd_org(); r.oy = rnd_org(); r.oz = rnd_org();
        r.dx = rnd_dir(); r.dy = rnd_dir(); r.dz = rnd_dir();
        send_ray(r, 1'b0, '0);
      end
      ray_if.valid <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
